>>> sv/p2a_pkg.sv
// Shared constants, register codes and period-length functions for the annual aggregator.
package p2a_pkg;

  // Field and state widths.
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned VALUE_W    = 41;
  localparam int unsigned YEAR_W     = 16;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned DTOT_W     = 9;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned SUB_W      = 15;
  localparam int unsigned M400_W     = 9;

  // Year arithmetic.
  localparam int unsigned START_YEAR_RST = 2000;
  localparam int unsigned CYCLE_YEARS    = 400;
  localparam int unsigned CENTURY        = 100;
  localparam int unsigned MOD_STEPS      = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_YEAR  = 2'd2;

  // Period mode codes; the unused code behaves as monthly.
  localparam logic [1:0] MODE_MONTHLY = 2'd0;
  localparam logic [1:0] MODE_SPLIT   = 2'd1;
  localparam logic [1:0] MODE_WEEKLY  = 2'd2;

  // Number of periods in one year for a period mode.
  function automatic logic [IDX_W-1:0] periods_per_year(input logic [1:0] mode);
    logic [IDX_W-1:0] n;
    case (mode)
      MODE_SPLIT:  n = 6'd14;
      MODE_WEEKLY: n = 6'd52;
      default:     n = 6'd12;
    endcase
    return n;
  endfunction

  // Leap test on the year counter taken modulo 400.
  function automatic logic is_leap(input logic [M400_W-1:0] m400);
    return (m400[1:0] == 2'b00) &&
           (m400 != M400_W'(CENTURY)) &&
           (m400 != M400_W'(2 * CENTURY)) &&
           (m400 != M400_W'(3 * CENTURY));
  endfunction

  // Length in days of one period.
  function automatic logic [DAY_W-1:0] period_days(input logic [1:0]       mode,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic             leap);
    logic [DAY_W-1:0] d;
    d = '0;
    case (mode)
      MODE_SPLIT: begin
        case (idx)
          6'd0:    d = 5'd31;
          6'd1:    d = 5'd15;
          6'd2:    d = 5'd16;
          6'd3:    d = 5'd30;
          6'd4:    d = 5'd31;
          6'd5:    d = 5'd30;
          6'd6:    d = 5'd31;
          6'd7:    d = 5'd31;
          6'd8:    d = leap ? 5'd29 : 5'd28;
          6'd9:    d = 5'd31;
          6'd10:   d = 5'd15;
          6'd11:   d = 5'd15;
          6'd12:   d = 5'd31;
          6'd13:   d = 5'd30;
          default: d = 5'd0;
        endcase
      end
      MODE_WEEKLY: begin
        if (idx < 6'd51) begin
          d = 5'd7;
        end else if (idx == 6'd51) begin
          d = leap ? 5'd9 : 5'd8;
        end
      end
      default: begin
        case (idx)
          6'd0:    d = 5'd31;
          6'd1:    d = 5'd30;
          6'd2:    d = 5'd31;
          6'd3:    d = 5'd31;
          6'd4:    d = leap ? 5'd29 : 5'd28;
          6'd5:    d = 5'd31;
          6'd6:    d = 5'd30;
          6'd7:    d = 5'd31;
          6'd8:    d = 5'd30;
          6'd9:    d = 5'd31;
          6'd10:   d = 5'd31;
          6'd11:   d = 5'd30;
          default: d = 5'd0;
        endcase
      end
    endcase
    return d;
  endfunction

endpackage

>>> sv/periodic_to_annual_aggregator.sv
// Periodic-to-annual flow aggregator with a shared subtract unit for division and year modulo.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      in_valid_i / in_ready_o    flow_sample_i (32 b signed)
//  out      output     out_valid_o / out_ready_i  annual_value_o (41 b signed), value_year_o (16 b)
//  cfg      input      cfg_we_i                   cfg_idx_i (2 b), cfg_wdata_i (14 b)
//
//  A beat that does not end a year is captured in IDLE and accumulated in ACC.
//  A year end in sum mode passes through ACC and DONE; in average mode through ACC, NEG, DIV
//  and DONE; the bit-serial restoring divider gives one quotient bit per cycle over 48 bits.
//  A start_year write runs a modulo-400 pass on the shared subtractor; no beat is taken.
//  Reset is asynchronous and active low; no clearing pass follows it.
//  A finished year waits in the output register; a stalled output only holds the
//  block when the next year end arrives before the previous result is taken.
module periodic_to_annual_aggregator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [p2a_pkg::SAMPLE_W-1:0] flow_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [p2a_pkg::VALUE_W-1:0]  annual_value_o,
  output logic [p2a_pkg::YEAR_W-1:0]        value_year_o,
  input  logic                              cfg_we_i,
  input  logic [p2a_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [p2a_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ACC  = 6'b000010,
    ST_NEG  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_DONE = 6'b010000,
    ST_MODY = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [1:0] period_mode_q, period_mode_d;
  logic       unit_mode_q, unit_mode_d;

  // Year state.
  logic [p2a_pkg::YEAR_W-1:0]     year_q, year_d;
  logic [p2a_pkg::M400_W-1:0]     m400_q, m400_d;
  logic [p2a_pkg::CFG_DATA_W-1:0] mod_q, mod_d;
  logic [p2a_pkg::IDX_W-1:0]      pidx_q, pidx_d;
  logic signed [p2a_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [p2a_pkg::DTOT_W-1:0]     dtot_q, dtot_d;

  // Beat capture and divider state.
  logic signed [p2a_pkg::SAMPLE_W-1:0] sample_q, sample_d;
  logic [p2a_pkg::SUM_W-1:0]      quo_q, quo_d;
  logic [p2a_pkg::DTOT_W-1:0]     rem_q, rem_d;
  logic                           neg_q, neg_d;
  logic [p2a_pkg::CNT_W-1:0]      cnt_q, cnt_d;

  // Output register.
  logic                              ovalid_q, ovalid_d;
  logic signed [p2a_pkg::VALUE_W-1:0] oval_q, oval_d;
  logic [p2a_pkg::YEAR_W-1:0]        oyear_q, oyear_d;

  // Shared trial subtractor.
  logic [p2a_pkg::SUB_W-1:0] sub_a, sub_b;
  logic [p2a_pkg::SUB_W:0]   sub_diff;
  logic                      sub_ge;
  logic [p2a_pkg::DTOT_W:0]  div_r;

  // Accumulate path.
  logic [p2a_pkg::IDX_W-1:0]      nper, idx_eff;
  logic [p2a_pkg::DAY_W-1:0]      days;
  logic signed [37:0]             prod;
  logic signed [p2a_pkg::SUM_W-1:0] addend, sum_new;
  logic                           last_period;
  logic signed [p2a_pkg::SUM_W-1:0] result;
  logic                           can_load;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = ovalid_q;
  assign annual_value_o = oval_q;
  assign value_year_o   = oyear_q;

  // Period lookup and the accumulate step.
  assign nper        = p2a_pkg::periods_per_year(period_mode_q);
  assign idx_eff     = (pidx_q >= nper) ? '0 : pidx_q;
  assign days        = p2a_pkg::period_days(period_mode_q, idx_eff, p2a_pkg::is_leap(m400_q));
  assign prod        = sample_q * $signed({1'b0, days});
  assign addend      = unit_mode_q ? p2a_pkg::SUM_W'(prod) : p2a_pkg::SUM_W'(sample_q);
  assign sum_new     = sum_q + addend;
  assign last_period = ((idx_eff + 6'd1) == nper);

  // Shared subtract unit: divider step or modulo-400 step.
  assign div_r = {rem_q, quo_q[p2a_pkg::SUM_W-1]};
  always_comb begin
    if (state_q == ST_MODY) begin
      sub_a = p2a_pkg::SUB_W'(mod_q);
      sub_b = p2a_pkg::SUB_W'(p2a_pkg::SUB_W'(p2a_pkg::CYCLE_YEARS) << cnt_q[2:0]);
    end else begin
      sub_a = p2a_pkg::SUB_W'(div_r);
      sub_b = p2a_pkg::SUB_W'(dtot_q);
    end
  end
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[p2a_pkg::SUB_W];

  // Year-end value: plain sum or signed quotient.
  assign result   = unit_mode_q ? (neg_q ? -$signed(quo_q) : $signed(quo_q)) : sum_q;
  assign can_load = !ovalid_q || out_ready_i;

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    period_mode_d = period_mode_q;
    unit_mode_d   = unit_mode_q;
    year_d        = year_q;
    m400_d        = m400_q;
    mod_d         = mod_q;
    pidx_d        = pidx_q;
    sum_d         = sum_q;
    dtot_d        = dtot_q;
    sample_d      = sample_q;
    quo_d         = quo_q;
    rem_d         = rem_q;
    neg_d         = neg_q;
    cnt_d         = cnt_q;
    oval_d        = oval_q;
    oyear_d       = oyear_q;
    ovalid_d      = ovalid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sample_d = flow_sample_i;
          state_d  = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_d  = sum_new;
        dtot_d = dtot_q + p2a_pkg::DTOT_W'(days);
        if (!last_period) begin
          pidx_d  = idx_eff + 6'd1;
          state_d = ST_IDLE;
        end else if (unit_mode_q) begin
          state_d = ST_NEG;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_NEG: begin
        // Divide the magnitude; a zero day count yields zero.
        neg_d = sum_q[p2a_pkg::SUM_W-1];
        rem_d = '0;
        cnt_d = p2a_pkg::CNT_W'(p2a_pkg::SUM_W - 1);
        if (dtot_q == '0) begin
          quo_d   = '0;
          state_d = ST_DONE;
        end else begin
          quo_d   = sum_q[p2a_pkg::SUM_W-1] ? p2a_pkg::SUM_W'(-sum_q) : p2a_pkg::SUM_W'(sum_q);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = sub_ge ? sub_diff[p2a_pkg::DTOT_W-1:0] : div_r[p2a_pkg::DTOT_W-1:0];
        quo_d = {quo_q[p2a_pkg::SUM_W-2:0], sub_ge};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          oval_d   = result[p2a_pkg::VALUE_W-1:0];
          oyear_d  = year_q;
          year_d   = year_q + 16'd1;
          if (year_q == '1) begin
            m400_d = '0;
          end else if (m400_q == p2a_pkg::M400_W'(p2a_pkg::CYCLE_YEARS - 1)) begin
            m400_d = '0;
          end else begin
            m400_d = m400_q + 9'd1;
          end
          pidx_d  = '0;
          sum_d   = '0;
          dtot_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_MODY: begin
        // Restoring remainder of the start year by 400, one shifted multiple per cycle.
        if (sub_ge) begin
          mod_d = sub_diff[p2a_pkg::CFG_DATA_W-1:0];
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          m400_d  = sub_ge ? sub_diff[p2a_pkg::M400_W-1:0] : mod_q[p2a_pkg::M400_W-1:0];
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Writes to the three defined registers start a new year; index 3 is ignored.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        p2a_pkg::REG_PERIOD_MODE: begin
          period_mode_d = cfg_wdata_i[1:0];
          pidx_d = '0;
          sum_d  = '0;
          dtot_d = '0;
        end
        p2a_pkg::REG_UNIT_MODE: begin
          unit_mode_d = cfg_wdata_i[0];
          pidx_d = '0;
          sum_d  = '0;
          dtot_d = '0;
        end
        p2a_pkg::REG_START_YEAR: begin
          year_d  = p2a_pkg::YEAR_W'(cfg_wdata_i);
          mod_d   = cfg_wdata_i;
          cnt_d   = p2a_pkg::CNT_W'(p2a_pkg::MOD_STEPS - 1);
          state_d = ST_MODY;
          pidx_d  = '0;
          sum_d   = '0;
          dtot_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      period_mode_q <= p2a_pkg::MODE_MONTHLY;
      unit_mode_q   <= 1'b0;
      year_q        <= p2a_pkg::YEAR_W'(p2a_pkg::START_YEAR_RST);
      m400_q        <= p2a_pkg::M400_W'(p2a_pkg::START_YEAR_RST % p2a_pkg::CYCLE_YEARS);
      pidx_q        <= '0;
      sum_q         <= '0;
      dtot_q        <= '0;
      cnt_q         <= '0;
      ovalid_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      period_mode_q <= period_mode_d;
      unit_mode_q   <= unit_mode_d;
      year_q        <= year_d;
      m400_q        <= m400_d;
      pidx_q        <= pidx_d;
      sum_q         <= sum_d;
      dtot_q        <= dtot_d;
      cnt_q         <= cnt_d;
      ovalid_q      <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mod_q    <= mod_d;
    sample_q <= sample_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
    oval_q   <= oval_d;
    oyear_q  <= oyear_d;
  end

  // An accepted beat takes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted back to back");

  // The year modulo stays in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m400_q < p2a_pkg::M400_W'(p2a_pkg::CYCLE_YEARS))
    else $error("year modulo out of range");

  // The divider remainder stays below the day count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < dtot_q))
    else $error("divider remainder not below divisor");

  // A new result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> $stable(oval_q) && $stable(oyear_q))
    else $error("pending result overwritten");

  // The period index stays inside the year while the block waits for a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (pidx_q < nper || pidx_q == '0))
    else $error("period index beyond year length");

endmodule
